### hw/rtl/hmlp_pkg.sv
// hmlp_pkg: shared constants and types for the linear-probe hash map.
// No dependencies; imported by hash_map_linear_probe.
package hmlp_pkg;

  // Table geometry. The slot count is a power of two, so the home slot is
  // the low SLOT_W bits of the hash.
  localparam int unsigned SLOT_W      = 10;
  localparam int unsigned TABLE_SLOTS = 1 << SLOT_W;

  localparam int unsigned KEY_W   = 63;
  localparam int unsigned VALUE_W = 64;

  // FNV-1a 64-bit. Only the low SLOT_W bits of the hash matter, and the low
  // bits of a product depend only on the low bits of its operands.
  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
  localparam logic [7:0]  BYTE_MASK = 8'hff;

  // Commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // Result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]         mark;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_row_t;

endpackage

### hw/rtl/hash_map_linear_probe.sv
// hash_map_linear_probe: key to value map in an open-addressed table with
// linear probing and tombstones. Depends on hmlp_pkg.
// Input channel (valid_i/stall_o) carries command, key and value; one word
// out (valid_o/stall_i) per request with status and found_value.
// After reset the block sweeps the table to mark every slot empty, with
// stall_o high. Then it takes one request at a time; stall_o stays high
// until that request's result is registered.
// Steps per request: accept, eight hash rounds (one FNV round per cycle
// through a shared SLOT_W x SLOT_W multiplier), then for each probed slot
// a registered read of the one-write, one-read slot memory, then compare and
// optional write, up to a full lap; last, the output register is loaded. The
// unused command code skips the hash rounds and the probes.
// The output register separates the sides: a new request is taken while a
// result waits; if the receiver stalls, the next result waits in the
// finish state until the register frees, and stall_o stays high meanwhile.
module hash_map_linear_probe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [1:0]                  command_i,
  input  logic [hmlp_pkg::KEY_W-1:0]  key_i,
  input  logic [hmlp_pkg::VALUE_W-1:0] value_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [1:0]                  status_o,
  output logic [hmlp_pkg::VALUE_W-1:0] found_value_o
);
  import hmlp_pkg::*;

  // sequencer codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_CHK   = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  localparam logic [SLOT_W-1:0] PRIME_LO = FNV_PRIME[SLOT_W-1:0];
  localparam logic [SLOT_W-1:0] BASIS_LO = FNV_BASIS[SLOT_W-1:0];
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  logic [2:0]         state_q, state_d;
  logic [SLOT_W-1:0]  clr_q, clr_d;

  // request registers
  logic [1:0]         cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;

  // hash and probe registers
  logic [SLOT_W-1:0]  hash_q, hash_d;
  logic [2:0]         byte_q, byte_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [SLOT_W-1:0]  count_q, count_d;
  logic               have_tomb_q, have_tomb_d;
  logic [SLOT_W-1:0]  tomb_q, tomb_d;

  // pending result
  logic [1:0]         res_status_q, res_status_d;
  logic [VALUE_W-1:0] res_found_q, res_found_d;

  // output register
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [VALUE_W-1:0] out_found_q;

  // slot memory
  slot_row_t          slot_mem_q [TABLE_SLOTS];
  slot_row_t          rd_row_q;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  slot_row_t          mem_wdata;

  logic               in_take;
  logic               out_free;
  logic [63:0]        key_wide;
  logic [7:0]         key_byte;
  logic [SLOT_W-1:0]  hash_mix;
  logic [2*SLOT_W-1:0] hash_prod;
  logic               key_hit;
  logic               lap_done;

  assign stall_o  = (state_q != ST_IDLE);
  assign in_take  = valid_i && !stall_o;
  assign out_free = !out_valid_q || !stall_i;

  // one FNV-1a round per cycle, low SLOT_W bits only
  assign key_wide  = {1'b0, key_q};
  assign key_byte  = key_wide[{byte_q, 3'b000} +: 8] & BYTE_MASK;
  assign hash_mix  = hash_q ^ SLOT_W'(key_byte);
  assign hash_prod = hash_mix * PRIME_LO;

  assign key_hit  = (rd_row_q.mark == MARK_USED) && (rd_row_q.key == key_q);
  assign lap_done = (count_q == LAST_SLOT);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    hash_d       = hash_q;
    byte_d       = byte_q;
    slot_d       = slot_q;
    count_d      = count_q;
    have_tomb_d  = have_tomb_q;
    tomb_d       = tomb_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    mem_we       = 1'b0;
    mem_waddr    = slot_q;
    mem_wdata    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        // sweep: every row becomes empty
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          hash_d       = BASIS_LO;
          byte_d       = '0;
          count_d      = '0;
          have_tomb_d  = 1'b0;
          res_status_d = ST_MISSING;
          res_found_d  = '0;
          // unused command code: no table access at all
          state_d = (command_i == CMD_INSERT || command_i == CMD_LOOKUP ||
                     command_i == CMD_DELETE) ? ST_HASH : ST_RESP;
        end
      end
      ST_HASH: begin
        hash_d = hash_prod[SLOT_W-1:0];
        byte_d = byte_q + 1'b1;
        if (byte_q == 3'd7) begin
          slot_d  = hash_prod[SLOT_W-1:0];
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (key_hit) begin
          res_status_d = ST_OK;
          state_d      = ST_RESP;
          if (cmd_q == CMD_INSERT) begin
            mem_we    = 1'b1;
            mem_wdata = '{mark: MARK_USED, key: key_q, value: value_q};
          end else if (cmd_q == CMD_LOOKUP) begin
            res_found_d = rd_row_q.value;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = '{mark: MARK_TOMB, key: rd_row_q.key, value: rd_row_q.value};
          end
        end else if (rd_row_q.mark == MARK_USED || rd_row_q.mark == MARK_TOMB) begin
          // probe on; an insert remembers the first tombstone
          if (cmd_q == CMD_INSERT && rd_row_q.mark == MARK_TOMB && !have_tomb_q) begin
            have_tomb_d = 1'b1;
            tomb_d      = slot_q;
          end
          if (lap_done) begin
            state_d = ST_RESP;
            if (cmd_q == CMD_INSERT) begin
              if (have_tomb_d) begin
                mem_we       = 1'b1;
                mem_waddr    = tomb_d;
                mem_wdata    = '{mark: MARK_USED, key: key_q, value: value_q};
                res_status_d = ST_OK;
              end else begin
                res_status_d = ST_FULL;
              end
            end
          end else begin
            count_d = count_q + 1'b1;
            slot_d  = slot_q + 1'b1;
            state_d = ST_RD;
          end
        end else begin
          // empty slot (or the unused mark code) ends the chain
          state_d = ST_RESP;
          if (cmd_q == CMD_INSERT) begin
            mem_we       = 1'b1;
            mem_waddr    = have_tomb_q ? tomb_q : slot_q;
            mem_wdata    = '{mark: MARK_USED, key: key_q, value: value_q};
            res_status_d = ST_OK;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (state_q == ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= command_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    hash_q       <= hash_d;
    byte_q       <= byte_d;
    slot_q       <= slot_d;
    count_q      <= count_d;
    have_tomb_q  <= have_tomb_d;
    tomb_q       <= tomb_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    if (state_q == ST_RESP && out_free) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
    end
  end

  // slot memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_row_q <= slot_mem_q[slot_q];
  end

  assign valid_o       = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_found_q;

  // checks
  a_rise_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(state_q) == ST_RESP)
    else $error("result appeared without a finished request");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !out_valid_q)
    else $error("result during clearing sweep");

  a_found_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && found_value_o != '0 |-> status_o == ST_OK)
    else $error("non-zero found value with failing status");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CHK || state_q == ST_CLEAR))
    else $error("slot memory written outside sweep or check");

endmodule

### test/hmlp_reply_checker.sv
// hmlp_reply_checker: watches both channels of hash_map_linear_probe, keeps its
// own copy of the slot table and checks every reply word in order.
// Depends on hmlp_pkg.
module hmlp_reply_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic                         req_stall_i,
  input  logic [1:0]                   command_i,
  input  logic [hmlp_pkg::KEY_W-1:0]   key_i,
  input  logic [hmlp_pkg::VALUE_W-1:0] value_i,
  input  logic                         rsp_valid_i,
  input  logic                         rsp_stall_i,
  input  logic [1:0]                   status_i,
  input  logic [hmlp_pkg::VALUE_W-1:0] found_value_i,
  output int                           error_count_o,
  output int                           in_flight_o
);
  import hmlp_pkg::*;

  typedef struct {
    logic [1:0]         status;
    logic [VALUE_W-1:0] found;
    int                 seq;
  } reply_t;

  logic [1:0]         slot_mark [TABLE_SLOTS];
  logic [KEY_W-1:0]   slot_key  [TABLE_SLOTS];
  logic [VALUE_W-1:0] slot_val  [TABLE_SLOTS];
  reply_t             due_replies [$];
  int                 req_seq;

  // FNV-1a over the eight key bytes, low byte first; table size is a power of two
  function automatic logic [SLOT_W-1:0] home_of(input logic [KEY_W-1:0] key);
    logic [63:0] h;
    logic [63:0] wide;
    h    = FNV_BASIS;
    wide = {1'b0, key};
    for (int b = 0; b < 8; b++) begin
      h = (h ^ ((wide >> (8 * b)) & {56'd0, BYTE_MASK})) * FNV_PRIME;
    end
    return h[SLOT_W-1:0];
  endfunction

  // Applies one request to the table copy and returns the reply it should give
  function automatic reply_t map_request(input logic [1:0] cmd,
                                         input logic [KEY_W-1:0] key,
                                         input logic [VALUE_W-1:0] val);
    reply_t             r;
    logic [SLOT_W-1:0]  s;
    logic [SLOT_W-1:0]  tomb;
    bit                 have_tomb;
    bit                 done;
    r.status  = ST_MISSING;
    r.found   = '0;
    r.seq     = 0;
    s         = home_of(key);
    tomb      = '0;
    have_tomb = 1'b0;
    done      = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        for (int n = 0; n < TABLE_SLOTS && !done; n++) begin
          if (slot_mark[s] == MARK_USED) begin
            if (slot_key[s] == key) begin
              slot_val[s] = val;
              done = 1'b1;
            end
          end else if (slot_mark[s] == MARK_TOMB) begin
            if (!have_tomb) begin
              have_tomb = 1'b1;
              tomb = s;
            end
          end else begin
            // empty (or the never-written code 3): key is absent
            if (have_tomb) s = tomb;
            slot_mark[s] = MARK_USED;
            slot_key[s]  = key;
            slot_val[s]  = val;
            done = 1'b1;
          end
          if (!done) s = s + 1'b1;
        end
        if (!done && have_tomb) begin
          slot_mark[tomb] = MARK_USED;
          slot_key[tomb]  = key;
          slot_val[tomb]  = val;
          done = 1'b1;
        end
        r.status = done ? ST_OK : ST_FULL;
      end
      CMD_LOOKUP, CMD_DELETE: begin
        for (int n = 0; n < TABLE_SLOTS && !done; n++) begin
          if (slot_mark[s] == MARK_USED && slot_key[s] == key) begin
            r.status = ST_OK;
            if (cmd == CMD_LOOKUP) r.found = slot_val[s];
            else slot_mark[s] = MARK_TOMB;
            done = 1'b1;
          end else if (slot_mark[s] != MARK_USED && slot_mark[s] != MARK_TOMB) begin
            done = 1'b1;
          end else begin
            s = s + 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SLOTS; i++) slot_mark[i] = MARK_EMPTY;
      due_replies.delete();
      req_seq     = 0;
      in_flight_o = 0;
    end else begin
      // replies first: a word accepted now cannot belong to a request taken now
      if (rsp_valid_i && !rsp_stall_i) begin
        if (due_replies.size() == 0) begin
          error_count_o++;
          if (error_count_o <= 10)
            $display("[%0t] reply with none due: status %0d found %h",
                     $realtime, status_i, found_value_i);
        end else begin
          want = due_replies.pop_front();
          if (status_i !== want.status || found_value_i !== want.found) begin
            error_count_o++;
            if (error_count_o <= 10)
              $display("[%0t] request %0d: status exp %0d got %0d, found exp %h got %h",
                       $realtime, want.seq, want.status, status_i,
                       want.found, found_value_i);
          end
        end
      end
      if (req_valid_i && !req_stall_i) begin
        want     = map_request(command_i, key_i, value_i);
        want.seq = req_seq;
        req_seq++;
        due_replies.push_back(want);
      end
      in_flight_o = due_replies.size();
    end
  end

endmodule

### test/hash_map_linear_probe_tb.sv
// hash_map_linear_probe_tb: stimulus and verdict for hash_map_linear_probe.
// Depends on hmlp_pkg, hash_map_linear_probe and hmlp_reply_checker.
// The checker does all prediction; this module only drives words and judges.
module hash_map_linear_probe_tb;
  import hmlp_pkg::*;

  // Code 3 is not a command; the block must answer it with not-found
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int              POOL_SIZE   = 256;
  localparam int              RAND_WORDS  = 730;
  // Cycles with nothing moving on either side; this is well clear of a
  // full-lap probe and of the post-reset sweep.
  localparam int              STUCK_LIMIT = 20000;
  localparam logic [KEY_W-1:0] KEY_MAX    = '1;

  logic               clk_i;
  logic               rst_ni;
  logic               valid_i;
  logic               stall_o;
  logic [1:0]         command_i;
  logic [KEY_W-1:0]   key_i;
  logic [VALUE_W-1:0] value_i;
  logic               valid_o;
  logic               stall_i;
  logic [1:0]         status_o;
  logic [VALUE_W-1:0] found_value_o;

  int                 fail_count;
  int                 in_flight;
  int                 idle_pct;
  int                 stall_pct;
  int                 stuck;
  logic [KEY_W-1:0]   key_pool [POOL_SIZE];

  hash_map_linear_probe dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .command_i     (command_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .status_o      (status_o),
    .found_value_o (found_value_o)
  );

  hmlp_reply_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (valid_i),
    .req_stall_i   (stall_o),
    .command_i     (command_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .rsp_valid_i   (valid_o),
    .rsp_stall_i   (stall_i),
    .status_i      (status_o),
    .found_value_i (found_value_o),
    .error_count_o (fail_count),
    .in_flight_o   (in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver back-pressure: redrawn every falling edge, so stalls land on
  // any phase of the block's probe loop.
  always @(negedge clk_i) begin
    stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Watchdog: ends the run if no word moves on either channel for too long
  initial begin
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) stuck = 0;
      else stuck++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Presents one request word from a falling edge and holds it until taken.
  // Returns at the falling edge after acceptance with valid_i still high, so a
  // back-to-back word only changes the payload (one assignment per step).
  task automatic send_word(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i   <= 1'b1;
    command_i <= cmd;
    key_i     <= key;
    value_i   <= val;
    do @(posedge clk_i); while (stall_o);
    @(negedge clk_i);
  endtask

  // Sender goes quiet until every reply due has arrived
  task automatic drain;
    valid_i <= 1'b0;
    @(negedge clk_i);
    while (in_flight != 0) @(negedge clk_i);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    int               r;

    rst_ni    = 1'b0;
    valid_i   = 1'b0;
    command_i = CMD_INSERT;
    key_i     = '0;
    value_i   = '0;
    idle_pct  = 15;
    stall_pct = 15;

    // Pool: zero, all ones, every single key bit, then random keys
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    for (int i = 0; i < KEY_W; i++) key_pool[i + 2] = KEY_W'(1) << i;
    for (int i = KEY_W + 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'({$urandom(), $urandom()});

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- Directed words ----
    // Misses on an empty table, and the unused command code
    send_word(CMD_LOOKUP, '0, '1);
    send_word(CMD_DELETE, '0, '0);
    send_word(CMD_UNUSED, '0, '1);
    // Key and value extremes
    send_word(CMD_INSERT, '0, '0);
    send_word(CMD_INSERT, KEY_MAX, '1);
    send_word(CMD_LOOKUP, '0, '1);
    send_word(CMD_LOOKUP, KEY_MAX, '0);
    // Update of a present key replaces its value
    send_word(CMD_INSERT, '0, 64'haaaa_aaaa_aaaa_aaaa);
    send_word(CMD_LOOKUP, '0, '0);
    send_word(CMD_INSERT, '0, 64'h5555_5555_5555_5555);
    send_word(CMD_LOOKUP, '0, '0);
    // Delete leaves a tombstone; a second delete and a lookup both miss
    send_word(CMD_DELETE, KEY_MAX, '0);
    send_word(CMD_LOOKUP, KEY_MAX, '0);
    send_word(CMD_DELETE, KEY_MAX, '0);
    // Re-insert lands in the tombstone it left
    send_word(CMD_INSERT, KEY_MAX, 64'h0123_4567_89ab_cdef);
    send_word(CMD_LOOKUP, KEY_MAX, '0);
    // Unused code on a present key must not look it up or remove it
    send_word(CMD_UNUSED, '0, '1);
    send_word(CMD_LOOKUP, '0, '0);
    send_word(CMD_INSERT, key_pool[2], 64'h8000_0000_0000_0001);
    send_word(CMD_LOOKUP, key_pool[2], '0);

    // ---- Random words ----
    // Mostly pool keys so lookups and deletes hit and probe chains build up;
    // a tenth are fresh keys that usually miss.
    for (int i = 0; i < RAND_WORDS; i++) begin
      // one long stretch with neither side idling
      if (i == 300) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      if (i == 450) begin
        idle_pct  = 15;
        stall_pct = 15;
      end
      if (i == 500) drain();
      r = $urandom_range(99);
      if (r < 45)      cmd = CMD_INSERT;
      else if (r < 75) cmd = CMD_LOOKUP;
      else if (r < 95) cmd = CMD_DELETE;
      else             cmd = CMD_UNUSED;
      if ($urandom_range(9) == 0) key = KEY_W'({$urandom(), $urandom()});
      else key = key_pool[$urandom_range(POOL_SIZE - 1)];
      send_word(cmd, key, rand_value());
    end

    drain();
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && in_flight == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### hash_map_linear_probe.f
hw/rtl/hmlp_pkg.sv
hw/rtl/hash_map_linear_probe.sv
test/hmlp_reply_checker.sv
test/hash_map_linear_probe_tb.sv
